// ===== hdl/y2r_pkg.sv =====
// ----------------------------------------------------------------------------
// y2r_pkg
// Types and fixed constants of the Y411 to RGB24 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SUM_W     = 24;

    // Q1.14 color coefficients, magnitudes; signs are applied in the front end
    localparam logic signed [SUM_W-1:0] K_RU = 24'sd15;
    localparam logic signed [SUM_W-1:0] K_RV = 24'sd22965;
    localparam logic signed [SUM_W-1:0] K_GU = 24'sd5631;
    localparam logic signed [SUM_W-1:0] K_GV = 24'sd11701;
    localparam logic signed [SUM_W-1:0] K_BU = 24'sd29035;
    localparam logic signed [SUM_W-1:0] K_BV = 24'sd16;

    localparam logic [8:0] CHROMA_OFFSET = 9'd128;
    localparam logic [7:0] CHANNEL_MAX   = 8'd255;

    typedef struct packed {
        logic [7:0] chroma_u;
        logic [7:0] luma_0;
        logic [7:0] luma_1;
        logic [7:0] chroma_v;
        logic [7:0] luma_2;
        logic [7:0] luma_3;
        logic       frame_last_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       group_last;
        logic       frame_last_out;
    } pixel_t;

    // One group after the chroma terms are worked out
    typedef struct packed {
        logic signed [SUM_W-1:0] r_off;
        logic signed [SUM_W-1:0] g_off;
        logic signed [SUM_W-1:0] b_off;
        logic [3:0][7:0]         luma;
        logic                    frame_last;
    } group_t;

endpackage

`default_nettype wire

// ===== hdl/y411_to_rgb24_converter.sv =====
// ----------------------------------------------------------------------------
// y411_to_rgb24_converter
// Y411 group in, four RGB24 pixels out.
// ----------------------------------------------------------------------------
// Input channel: drive item with one Y411 group and raise push; the group is
// taken on a clock edge where push is high and full is low.
// Output channel: while empty is low, pixel carries the oldest waiting pixel;
// raise pop to take it. Pixels leave in luma order; the fourth of each group
// has group_last set and carries the group's frame end mark.
// The first pixel of a group passes the front register, the queue and the
// sequencer's group register into the single output register; the other three
// follow one per cycle while the receiver keeps taking them. The pixel sequencer
// loads the next group as it produces the last pixel of the current one.
// The front end keeps accepting while pixels wait: groups collect in a queue
// of QUEUE_DEPTH entries plus the front register, and only then full rises.
// A stalled receiver holds the shown pixel stable.
// Reset empties the queue and the pipeline; no pixel is shown after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module y411_to_rgb24_converter
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire y2r_pkg::in_item_t item,
    output logic                   full,
    output logic                   empty,
    input  wire logic              pop,
    output y2r_pkg::pixel_t        pixel
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    y2r_pkg::group_t q_wr_data;
    y2r_pkg::group_t q_rd_data;

    y2r_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_push (q_push),
        .q_data (q_wr_data),
        .q_full (q_full)
    );

    y2r_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    y2r_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .pixel   (pixel)
    );

endmodule

`default_nettype wire

// ===== hdl/y2r_front.sv =====
// ----------------------------------------------------------------------------
// y2r_front
// Accepts Y411 groups and forms the three chroma offsets of each group.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire y2r_pkg::in_item_t item,
    output logic                   full,
    output logic                   q_push,
    output y2r_pkg::group_t        q_data,
    input  wire logic              q_full
);

    logic                         valid_reg;
    logic                         valid_next;
    y2r_pkg::group_t              grp_reg;
    y2r_pkg::group_t              grp_next;
    logic                         accept;
    logic signed [8:0]            du;
    logic signed [8:0]            dv;
    logic signed [y2r_pkg::SUM_W-1:0] du_w;
    logic signed [y2r_pkg::SUM_W-1:0] dv_w;

    assign q_push = valid_reg && !q_full;
    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_data = grp_reg;

    always_comb
    begin
        du   = $signed({1'b0, item.chroma_u} - y2r_pkg::CHROMA_OFFSET);
        dv   = $signed({1'b0, item.chroma_v} - y2r_pkg::CHROMA_OFFSET);
        du_w = y2r_pkg::SUM_W'(du);
        dv_w = y2r_pkg::SUM_W'(dv);

        grp_next.r_off      = y2r_pkg::K_RV * dv_w - y2r_pkg::K_RU * du_w;
        grp_next.g_off      = -(y2r_pkg::K_GU * du_w) - y2r_pkg::K_GV * dv_w;
        grp_next.b_off      = y2r_pkg::K_BU * du_w + y2r_pkg::K_BV * dv_w;
        grp_next.luma[0]    = item.luma_0;
        grp_next.luma[1]    = item.luma_1;
        grp_next.luma[2]    = item.luma_2;
        grp_next.luma[3]    = item.luma_3;
        grp_next.frame_last = item.frame_last_in;

        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            grp_reg <= grp_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/y2r_fifo.sv =====
// ----------------------------------------------------------------------------
// y2r_fifo
// Short group queue between the front end and the pixel sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_fifo
#(
    parameter int DEPTH = 2
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire y2r_pkg::group_t wr_data,
    output logic                 full,
    input  wire logic            pop,
    output y2r_pkg::group_t      rd_data,
    output logic                 empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    y2r_pkg::group_t    mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/y2r_back.sv =====
// ----------------------------------------------------------------------------
// y2r_back
// Walks the four pixels of a queued group, one per cycle while the receiver
// keeps taking them, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_empty,
    input  wire y2r_pkg::group_t q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output y2r_pkg::pixel_t      pixel
);

    logic                              busy_reg;
    logic                              busy_next;
    logic [1:0]                        idx_reg;
    logic [1:0]                        idx_next;
    y2r_pkg::group_t                   grp_reg;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    y2r_pkg::pixel_t                   out_reg;
    y2r_pkg::pixel_t                   out_next;
    logic                              step;
    logic                              last;
    logic                              load;
    logic signed [y2r_pkg::SUM_W-1:0]  ys;

    function automatic logic [7:0] clamp_channel(input logic signed [y2r_pkg::SUM_W-1:0] sum);
        logic [7:0] res;
        if (sum[y2r_pkg::SUM_W-1])
        begin
            res = 8'd0;
        end
        else if (sum[y2r_pkg::SUM_W-2:y2r_pkg::FRAC_BITS+8] != '0)
        begin
            res = y2r_pkg::CHANNEL_MAX;
        end
        else
        begin
            res = sum[y2r_pkg::FRAC_BITS+7:y2r_pkg::FRAC_BITS];
        end
        return res;
    endfunction

    assign empty = !out_valid_reg;
    assign pixel = out_reg;
    assign step  = busy_reg && (!out_valid_reg || pop);
    assign last  = (idx_reg == 2'd3);
    assign load  = !q_empty && (!busy_reg || (step && last));
    assign q_pop = load;

    always_comb
    begin
        ys = $signed({2'b00, grp_reg.luma[idx_reg], {y2r_pkg::FRAC_BITS{1'b0}}});

        out_next.red            = clamp_channel(ys + grp_reg.r_off);
        out_next.green          = clamp_channel(ys + grp_reg.g_off);
        out_next.blue           = clamp_channel(ys + grp_reg.b_off);
        out_next.group_last     = last;
        out_next.frame_last_out = last && grp_reg.frame_last;

        if (load)
        begin
            busy_next = 1'b1;
        end
        else if (step && last)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            busy_next = busy_reg;
        end

        if (load)
        begin
            idx_next = 2'd0;
        end
        else if (step)
        begin
            idx_next = idx_reg + 2'd1;
        end
        else
        begin
            idx_next = idx_reg;
        end

        // hold the pixel until it is taken, refill on every step
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= q_data;
        end
        if (step)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire
